// File: design/hdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdm_pkg
// Shared constants for the hemisphere direction map: CORDIC length, gain and
// arctangent table in units of 2^-32 turn.
// ----------------------------------------------------------------------------
package hdm_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 33;  // CORDIC x/y width, signed Q2.30 plus headroom

  typedef logic signed [CW-1:0] cordic_xy_t;
  typedef logic [31:0]          turn_t;

  localparam cordic_xy_t CORDIC_GAIN = 33'sd652032874;

  // Arctangent of 2^-i as a fraction of a full turn.
  function automatic turn_t atan_turn(input int step);
    turn_t a;
    case (step)
      0:  a = 32'h20000000;  1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;  3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;  9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;  11: a = 32'h000517CC;
      12: a = 32'h00028BE6;  13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;  15: a = 32'h0000517D;
      16: a = 32'h000028BE;  17: a = 32'h0000145F;
      18: a = 32'h00000A30;  19: a = 32'h00000518;
      20: a = 32'h0000028C;  21: a = 32'h00000146;
      22: a = 32'h000000A3;  23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

// File: design/hdm_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdm_sqrt_cell
// One digit of a pipelined restoring square root: takes two radicand bits,
// settles one root bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module hdm_sqrt_cell #(
  parameter int RW = 17,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2*RW-1:0] in_n,
  input  logic [RW+1:0]   in_rem,
  input  logic [RW-1:0]   in_root,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2*RW-1:0] out_n,
  output logic [RW+1:0]   out_rem,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  logic            vld_r, vld_nxt;
  logic [2*RW-1:0] n_r;
  logic [RW+1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [SW-1:0]   side_r;
  logic [RW+1:0]   rem_sh, trial;

  assign in_ready = !vld_r || out_ready;

  // Bring down the next two radicand bits and try the root bit at one.
  always_comb begin
    rem_sh = {in_rem[RW-1:0], in_n[2*RW-1 -: 2]};
    trial  = {1'b0, in_root[RW-2:0], 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {in_root[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {in_root[RW-2:0], 1'b0};
    end
    vld_nxt = in_ready ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      n_r    <= {in_n[2*RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = vld_r;
  assign out_n     = n_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

// File: design/hdm_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdm_cordic_cell
// One CORDIC rotation step with a fixed shift and arctangent, registered.
// ----------------------------------------------------------------------------
module hdm_cordic_cell #(
  parameter int STEP = 0,
  parameter int SW   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hdm_pkg::cordic_xy_t in_x,
  input  hdm_pkg::cordic_xy_t in_y,
  input  hdm_pkg::turn_t      in_z,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output hdm_pkg::cordic_xy_t out_x,
  output hdm_pkg::cordic_xy_t out_y,
  output hdm_pkg::turn_t      out_z,
  output logic [SW-1:0]       out_side
);

  localparam hdm_pkg::turn_t ATAN = hdm_pkg::atan_turn(STEP);

  logic                vld_r, vld_nxt;
  hdm_pkg::cordic_xy_t x_r, y_r, x_nxt, y_nxt, dx, dy;
  hdm_pkg::turn_t      z_r, z_nxt;
  logic [SW-1:0]       side_r;

  assign in_ready = !vld_r || out_ready;

  // Rotate towards zero residual angle; arithmetic shifts floor.
  always_comb begin
    dx = in_y >>> STEP;
    dy = in_x >>> STEP;
    if (in_z[31]) begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ATAN;
    end else begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ATAN;
    end
    vld_nxt = in_ready ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = vld_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_side  = side_r;

endmodule

// File: design/hemisphere_direction_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hemisphere_direction_map
// Maps a unit-square sample to a direction on the hemisphere around +z,
// uniform or cosine-weighted by the density mode register.
// Stages: input register, two square root cell rows of FRAC_BITS+1 cells,
// select/square, 24 CORDIC cells, quadrant, multiply, round and output
// register. Throughput: one word per cycle; each cell stalls only when it
// is full and its successor is full and stalled.
// Reset clears all valid flags and sets the density mode to cosine-weighted.
// ----------------------------------------------------------------------------
module hemisphere_direction_map #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // density_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,       // sample_u[15:0], sample_v[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata       // dir_x[17:0], dir_y[35:18], dir_z[52:36]
);

  localparam int RW  = FRAC_BITS + 1;
  localparam int NW  = 2 * RW;
  localparam int PW  = FRAC_BITS + 34;
  localparam int NS  = hdm_pkg::CORDIC_STEPS;
  localparam int S1W = 16 + 1 + RW;   // u, mode, uniform cos
  localparam int S2W = 16 + RW;       // u, c
  localparam int S3W = RW + RW + 2;   // s, c, quadrant
  localparam logic [RW-1:0] ONE      = RW'(1) << FRAC_BITS;
  localparam logic [NW-1:0] ONE_SQ   = NW'(1) << (2 * FRAC_BITS);
  localparam logic signed [PW-1:0] ONE_P  = PW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) << 29;

  // Configuration register.
  logic mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Input stage: t = 1 - v, the radicand for the cosine mode and the uniform cos.
  logic            f0_vld_r, f0_rdy;
  logic [15:0]     f0_u_r;
  logic            f0_mode_r;
  logic [NW-1:0]   f0_n_r;
  logic [RW-1:0]   f0_cu_r;
  logic [16:0]     t_w;
  logic [16+FRAC_BITS:0] tsh_w;

  assign t_w   = 17'h10000 - {1'b0, in_tdata[31:16]};
  assign tsh_w = {t_w, FRAC_BITS'(0)} >> 16;
  assign in_tready = !f0_vld_r || f0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
    end else if (in_tready) begin
      f0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      f0_u_r    <= in_tdata[15:0];
      f0_mode_r <= mode_r;
      f0_n_r    <= NW'(t_w) << (2 * FRAC_BITS - 16);
      f0_cu_r   <= tsh_w[RW-1:0];
    end
  end

  // First square root row: c = sqrt(t) in the cosine mode.
  logic            a_vld [RW+1];
  logic            a_rdy [RW+1];
  logic [NW-1:0]   a_n   [RW+1];
  logic [RW+1:0]   a_rem [RW+1];
  logic [RW-1:0]   a_root[RW+1];
  logic [S1W-1:0]  a_side[RW+1];

  assign a_vld[0]  = f0_vld_r;
  assign f0_rdy    = a_rdy[0];
  assign a_n[0]    = f0_n_r;
  assign a_rem[0]  = '0;
  assign a_root[0] = '0;
  assign a_side[0] = {f0_u_r, f0_mode_r, f0_cu_r};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt_a
    hdm_sqrt_cell #(.RW(RW), .SW(S1W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(a_vld[i]), .in_ready(a_rdy[i]),
      .in_n(a_n[i]), .in_rem(a_rem[i]), .in_root(a_root[i]), .in_side(a_side[i]),
      .out_valid(a_vld[i+1]), .out_ready(a_rdy[i+1]),
      .out_n(a_n[i+1]), .out_rem(a_rem[i+1]), .out_root(a_root[i+1]),
      .out_side(a_side[i+1])
    );
  end

  // Select cos theta by mode and square it.
  logic            m_vld_r, m_rdy;
  logic [15:0]     m_u_r;
  logic [RW-1:0]   m_c_r, c_sel;
  logic [NW-1:0]   m_cc_r;

  always_comb begin
    c_sel = a_side[RW][RW] ? a_root[RW] : a_side[RW][RW-1:0];
    if (c_sel > ONE) begin
      c_sel = ONE;
    end
  end

  assign a_rdy[RW] = !m_vld_r || m_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (a_rdy[RW]) begin
      m_vld_r <= a_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy[RW]) begin
      m_u_r  <= a_side[RW][S1W-1 -: 16];
      m_c_r  <= c_sel;
      m_cc_r <= c_sel * c_sel;
    end
  end

  // Second square root row: s = sqrt(1 - c^2).
  logic            b_vld [RW+1];
  logic            b_rdy [RW+1];
  logic [NW-1:0]   b_n   [RW+1];
  logic [RW+1:0]   b_rem [RW+1];
  logic [RW-1:0]   b_root[RW+1];
  logic [S2W-1:0]  b_side[RW+1];

  assign b_vld[0]  = m_vld_r;
  assign m_rdy     = b_rdy[0];
  assign b_n[0]    = ONE_SQ - m_cc_r;
  assign b_rem[0]  = '0;
  assign b_root[0] = '0;
  assign b_side[0] = {m_u_r, m_c_r};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt_b
    hdm_sqrt_cell #(.RW(RW), .SW(S2W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(b_vld[i]), .in_ready(b_rdy[i]),
      .in_n(b_n[i]), .in_rem(b_rem[i]), .in_root(b_root[i]), .in_side(b_side[i]),
      .out_valid(b_vld[i+1]), .out_ready(b_rdy[i+1]),
      .out_n(b_n[i+1]), .out_rem(b_rem[i+1]), .out_root(b_root[i+1]),
      .out_side(b_side[i+1])
    );
  end

  // CORDIC row on the residue of 2 pi u after removing the quadrant.
  logic                k_vld [NS+1];
  logic                k_rdy [NS+1];
  hdm_pkg::cordic_xy_t k_x   [NS+1];
  hdm_pkg::cordic_xy_t k_y   [NS+1];
  hdm_pkg::turn_t      k_z   [NS+1];
  logic [S3W-1:0]      k_side[NS+1];
  logic [15:0]         u_w, u_off;
  logic [1:0]          quad_w;

  assign u_w    = b_side[RW][S2W-1 -: 16];
  assign u_off  = u_w + 16'h2000;
  assign quad_w = u_off[15:14];

  assign k_vld[0]   = b_vld[RW];
  assign b_rdy[RW]  = k_rdy[0];
  assign k_x[0]     = hdm_pkg::CORDIC_GAIN;
  assign k_y[0]     = '0;
  assign k_z[0]     = {u_w - {quad_w, 14'b0}, 16'b0};
  assign k_side[0]  = {b_root[RW], b_side[RW][RW-1:0], quad_w};

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    hdm_cordic_cell #(.STEP(i), .SW(S3W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(k_vld[i]), .in_ready(k_rdy[i]),
      .in_x(k_x[i]), .in_y(k_y[i]), .in_z(k_z[i]), .in_side(k_side[i]),
      .out_valid(k_vld[i+1]), .out_ready(k_rdy[i+1]),
      .out_x(k_x[i+1]), .out_y(k_y[i+1]), .out_z(k_z[i+1]), .out_side(k_side[i+1])
    );
  end

  // Quadrant rotation by multiples of a quarter turn.
  logic                q_vld_r, q_rdy;
  logic signed [31:0]  q_co_r, q_si_r, co_w, si_w;
  logic [RW-1:0]       q_s_r, q_c_r;
  hdm_pkg::cordic_xy_t xe, ye, nx, ny;

  always_comb begin
    xe = k_x[NS];
    ye = k_y[NS];
    nx = -xe;
    ny = -ye;
    case (k_side[NS][1:0])
      2'd0:    begin co_w = xe[31:0]; si_w = ye[31:0]; end
      2'd1:    begin co_w = ny[31:0]; si_w = xe[31:0]; end
      2'd2:    begin co_w = nx[31:0]; si_w = ny[31:0]; end
      default: begin co_w = ye[31:0]; si_w = nx[31:0]; end
    endcase
  end

  assign k_rdy[NS] = !q_vld_r || q_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else if (k_rdy[NS]) begin
      q_vld_r <= k_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (k_rdy[NS]) begin
      q_co_r <= co_w;
      q_si_r <= si_w;
      q_s_r  <= k_side[NS][S3W-1 -: RW];
      q_c_r  <= k_side[NS][RW+1:2];
    end
  end

  // Scale by sin theta.
  logic                p_vld_r, p_rdy;
  logic signed [PW-1:0] p_x_r, p_y_r;
  logic [RW-1:0]       p_c_r;
  logic signed [RW:0]  s_sg;

  assign s_sg  = $signed({1'b0, q_s_r});
  assign q_rdy = !p_vld_r || p_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (q_rdy) begin
      p_vld_r <= q_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rdy) begin
      p_x_r <= PW'(s_sg * q_co_r);
      p_y_r <= PW'(s_sg * q_si_r);
      p_c_r <= q_c_r;
    end
  end

  // Round half up, saturate and register the output word.
  logic                 o_vld_r;
  logic [55:0]          o_data_r;
  logic signed [PW-1:0] rx, ry;
  logic [FRAC_BITS+17:0] c_ext;

  function automatic logic signed [PW-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + HALF_P) >>> 30;
    if (r > ONE_P) begin
      r = ONE_P;
    end else if (r < -ONE_P) begin
      r = -ONE_P;
    end
    return r;
  endfunction

  assign rx    = round_sat(p_x_r);
  assign ry    = round_sat(p_y_r);
  assign c_ext = {17'b0, p_c_r};
  assign p_rdy = !o_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (p_rdy) begin
      o_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy) begin
      o_data_r <= {3'b0, c_ext[16:0], ry[17:0], rx[17:0]};
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;

  // Cos theta never exceeds one at the default scaling.
  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (FRAC_BITS <= 16) |-> out_tdata[52:36] <= 17'h10000)
    else $error("dir_z above one");

  // The input may only stall while the first stage holds a word.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> f0_vld_r)
    else $error("input stalled with empty first stage");

  // A free output register always lets the last stage move on.
  a_out_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> p_rdy && q_rdy)
    else $error("pipeline stalled with empty output");

endmodule

// File: bench/tb_hemisphere_direction_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere direction map testbench
// Drives unit-square samples into the block, predicts each direction with an
// independent integer model (square roots, CORDIC, quadrant fold, rounding)
// and checks every output word in order, across both density modes.
// ----------------------------------------------------------------------------
module tb_hemisphere_direction_map;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = 2 * FRAC_BITS + 31;
  localparam int WATCHDOG  = 20000;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic        [16:0] z;
  } direction_t;

  // Tracks the expected directions and the number of mismatches.
  class direction_board;
    direction_t pending[$];
    int errors;
    logic mode;

    function new();
      errors = 0;
      mode = 1'b1;
    endfunction

    static function longint isqrt(longint n);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 << 60;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    static function longint sat_scale(longint mag, longint trig);
      longint r;
      longint one;
      one = 64'sd1 <<< FRAC_BITS;
      r = (mag * trig + (64'sd1 <<< 29)) >>> 30;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r;
    endfunction

    // Notes an accepted sample and works out its direction.
    function void note_sample(logic [15:0] u, logic [15:0] v);
      longint t, c, s, cx, cy, dx, dy, one;
      logic [31:0] ang, zr;
      logic [1:0] quad;
      direction_t d;
      one = 64'sd1 <<< FRAC_BITS;
      t = 65536 - longint'(v);
      if (mode) c = isqrt(t <<< (2 * FRAC_BITS - 16));
      else c = (t <<< FRAC_BITS) >>> 16;
      if (c > one) c = one;
      s = isqrt(one * one - c * c);
      ang = {u, 16'h0000};
      quad = 2'((ang + 32'h20000000) >> 30);
      zr = ang - {quad, 30'h0};
      cx = longint'(hdm_pkg::CORDIC_GAIN);
      cy = 0;
      for (int i = 0; i < hdm_pkg::CORDIC_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (zr[31]) begin
          cx = cx + dx; cy = cy - dy; zr = zr + hdm_pkg::atan_turn(i);
        end else begin
          cx = cx - dx; cy = cy + dy; zr = zr - hdm_pkg::atan_turn(i);
        end
      end
      case (quad)
        2'd0: begin dx = cx; dy = cy; end
        2'd1: begin dx = -cy; dy = cx; end
        2'd2: begin dx = -cx; dy = -cy; end
        default: begin dx = cy; dy = -cx; end
      endcase
      d.x = 18'(sat_scale(s, dx));
      d.y = 18'(sat_scale(s, dy));
      d.z = 17'(c);
      pending.push_back(d);
    endfunction

    // Compares one output word with the oldest expected direction.
    function void check_direction(logic [55:0] w);
      direction_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w[17:0] !== e.x) begin
        $display("%0t: dir_x expected %0d actual %0d", $time, e.x, $signed(w[17:0]));
        errors++;
      end
      if (w[35:18] !== e.y) begin
        $display("%0t: dir_y expected %0d actual %0d", $time, e.y, $signed(w[35:18]));
        errors++;
      end
      if (w[52:36] !== e.z) begin
        $display("%0t: dir_z expected %0d actual %0d", $time, e.z, w[52:36]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_wr_en, cfg_wr_data;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [31:0] in_tdata;
  logic [55:0] out_tdata;
  logic calm;
  int idle_cycles;
  direction_board board;

  hemisphere_direction_map #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side: random stalls, checks each accepted word.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_direction(out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 7);
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one sample word, with a random gap before it unless calm.
  task automatic send_sample(input logic [15:0] u, input logic [15:0] v);
    while (!calm && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v, u};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_sample(u, v);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.mode = m;
  endtask

  task automatic random_samples(input int n);
    logic [15:0] u, v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: u = 16'($urandom_range(3) * 16'h4000 + $urandom_range(4) - 2);
        1: u = 16'($urandom_range(7) * 16'h2000 + $urandom_range(2) - 1);
        default: u = 16'($urandom);
      endcase
      case ($urandom_range(4))
        0: v = 16'($urandom_range(8));
        1: v = 16'(16'hFFFF - $urandom_range(8));
        default: v = 16'($urandom);
      endcase
      send_sample(u, v);
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    calm = 1'b0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners under the reset mode (cosine-weighted).
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h4000, 16'h8000);
    send_sample(16'h8000, 16'h0001);
    send_sample(16'hC000, 16'hFFFE);
    send_sample(16'h2000, 16'h5555);
    send_sample(16'hE000, 16'hAAAA);
    send_sample(16'h1FFF, 16'h0000);
    send_sample(16'h6000, 16'h0000);
    send_sample(16'hA000, 16'h0000);
    drain();

    // The first five corners again under the uniform mode, then other corners and random samples.
    write_mode(1'b0);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h4000, 16'h8000);
    send_sample(16'h8000, 16'h0001);
    send_sample(16'hC000, 16'hFFFE);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    send_sample(16'h3FFF, 16'h0000);
    random_samples(300);
    drain();

    // Cosine mode, with a stretch that never stalls.
    write_mode(1'b1);
    random_samples(300);
    calm = 1'b1;
    random_samples(200);
    calm = 1'b0;
    drain();

    write_mode(1'b0);
    random_samples(250);
    drain();
    write_mode(1'b1);
    random_samples(230);
    drain();

    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
